// File: hdl/owhsr_pkg.sv
// ----------------------------------------------------------------------------
// owhsr_pkg
// Shared types and constants for the single-wire humidity sensor receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package owhsr_pkg;

   // Input word opcodes
   localparam logic OP_EDGE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // Sensor model codes (code 3 is treated as auto-detect)
   localparam logic [1:0] MODEL_AUTO  = 2'd0;
   localparam logic [1:0] MODEL_DHT11 = 2'd1;
   localparam logic [1:0] MODEL_WIDE  = 2'd2;

   // Register indexes (word addresses on the CSR port)
   localparam logic [1:0] REG_SENSOR_MODEL = 2'd0;
   localparam logic [1:0] REG_FRAME_GAP    = 2'd1;
   localparam logic [1:0] REG_ONE_BIT      = 2'd2;

   // Register reset values
   localparam logic [1:0]  SENSOR_MODEL_RESET = MODEL_DHT11;
   localparam logic [31:0] FRAME_GAP_RESET    = 32'd300000;
   localparam logic [31:0] ONE_BIT_RESET      = 32'd100000;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int FRAME_BITS     = 40;

   // Range limits, all in tenths except the whole-unit DHT11 limits
   localparam logic [7:0]  DHT11_TEMP_MAX = 8'd60;
   localparam logic [7:0]  DHT11_HUM_MIN  = 8'd10;
   localparam logic [7:0]  DHT11_HUM_MAX  = 8'd90;
   localparam logic [15:0] WIDE_HUM_MAX   = 16'd1100;
   localparam logic [14:0] WIDE_TEMP_POS  = 15'd1350;
   localparam logic [14:0] WIDE_TEMP_NEG  = 15'd500;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] temperature;
      logic [15:0]        humidity;
   } result_type;

endpackage : owhsr_pkg

`default_nettype wire

// File: hdl/owhsr_decode.sv
// ----------------------------------------------------------------------------
// owhsr_decode
// Frame decoder: checksum, DHT11 / wide-format / auto-detect rules and
// range checks on one 40-bit frame.
// ----------------------------------------------------------------------------
`default_nettype none

module owhsr_decode (
   input  wire logic [owhsr_pkg::FRAME_BITS-1:0] frame_bits,
   input  wire logic [1:0]                       sensor_model,
   output owhsr_pkg::result_type                 result
);

   logic [7:0]  b0, b1, b2, b3, b4;
   logic [7:0]  sum;
   logic        sum_ok;

   logic               dht11_ok;
   logic signed [15:0] dht11_temp;
   logic [15:0]        dht11_hum;

   logic               wide_ok;
   logic [14:0]        wide_mag;
   logic signed [15:0] wide_temp;
   logic [15:0]        wide_hum;

   logic               use_wide;
   logic               frame_ok;

   assign b0 = frame_bits[7:0];
   assign b1 = frame_bits[15:8];
   assign b2 = frame_bits[23:16];
   assign b3 = frame_bits[31:24];
   assign b4 = frame_bits[39:32];

   assign sum    = 8'(b1 + b2 + b3 + b4);
   assign sum_ok = (sum == b0);

   // DHT11: whole units in b2 / b4, fractional bytes must be zero
   assign dht11_temp = 16'(16'(b2) * 16'd10);
   assign dht11_hum  = 16'(16'(b4) * 16'd10);
   assign dht11_ok   = (b1 == 8'd0) && (b3 == 8'd0)
                       && (b2 <= owhsr_pkg::DHT11_TEMP_MAX)
                       && (b4 >= owhsr_pkg::DHT11_HUM_MIN)
                       && (b4 <= owhsr_pkg::DHT11_HUM_MAX);

   // Wide format: sign-magnitude temperature, a negative zero reads as zero
   assign wide_mag  = {b2[6:0], b1};
   assign wide_hum  = {b4, b3};
   assign wide_temp = b2[7] ? 16'(16'd0 - {1'b0, wide_mag}) : 16'({1'b0, wide_mag});
   assign wide_ok   = (wide_hum <= owhsr_pkg::WIDE_HUM_MAX)
                      && (b2[7] ? (wide_mag <= owhsr_pkg::WIDE_TEMP_NEG)
                                : (wide_mag <= owhsr_pkg::WIDE_TEMP_POS));

   always_comb begin
      case (sensor_model)
         owhsr_pkg::MODEL_DHT11: begin
            use_wide = 1'b0;
            frame_ok = dht11_ok;
         end
         owhsr_pkg::MODEL_WIDE: begin
            use_wide = 1'b1;
            frame_ok = wide_ok;
         end
         default: begin
            // auto-detect: wide first, then fall back to DHT11
            use_wide = wide_ok;
            frame_ok = wide_ok || dht11_ok;
         end
      endcase
   end

   always_comb begin
      result.temperature = '0;
      result.humidity    = '0;
      if (!sum_ok) begin
         result.status = owhsr_pkg::STATUS_CHECKSUM;
      end else if (!frame_ok) begin
         result.status = owhsr_pkg::STATUS_RANGE;
      end else begin
         result.status      = owhsr_pkg::STATUS_GOOD;
         result.temperature = use_wide ? wide_temp : dht11_temp;
         result.humidity    = use_wide ? wide_hum : dht11_hum;
      end
   end

endmodule : owhsr_decode

`default_nettype wire

// File: hdl/one_wire_humidity_sensor_receiver.sv
// ----------------------------------------------------------------------------
// one_wire_humidity_sensor_receiver
// Collects bits from rising-edge timestamps of a single-wire humidity and
// temperature sensor and decodes a frame on each line timeout.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake           word
//   req_      in          req_valid/stall     op, edge_time
//   rsp_      out         rsp_valid/stall     status, temperature, humidity
//   csr_      in/out      APB, pready = 1     sensor_model, frame gap, one bit
//
// One word is taken per cycle while req_stall is low. Edge words update the bit
// register in the accept cycle and give no result; a timeout word passes the
// frame register, then the result register, before its result appears.
// Synchronous reset clears control state and loads register defaults.
// req_stall rises only while a decoded frame waits behind a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_humidity_sensor_receiver (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic                                 req_op,
   input  wire logic [63:0]                          req_edge_time,

   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [1:0]                           rsp_status,
   output      logic signed [15:0]                   rsp_temperature_tenths,
   output      logic [15:0]                          rsp_humidity_tenths,

   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [owhsr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output      logic [31:0]                          csr_prdata,
   output      logic                                 csr_pready
);

   // CSR registers
   logic [1:0]  sensor_model_ff, sensor_model_in;
   logic [31:0] frame_gap_ff, frame_gap_in;
   logic [31:0] one_bit_ff, one_bit_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   // Receive state
   logic [owhsr_pkg::FRAME_BITS-1:0] bits_ff, bits_in;
   logic [63:0]                      prev_edge_ff, prev_edge_in;
   logic [63:0]                      gap;

   // Frame stage
   logic                             dec_valid_ff, dec_valid_in;
   logic [owhsr_pkg::FRAME_BITS-1:0] dec_bits_ff, dec_bits_in;
   owhsr_pkg::result_type            dec_result;

   // Result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   owhsr_pkg::result_type rsp_word_ff, rsp_word_in;

   logic req_accept;
   logic out_en;
   logic is_timeout;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sensor_model_in = sensor_model_ff;
      frame_gap_in    = frame_gap_ff;
      one_bit_in      = one_bit_ff;
      if (csr_write) begin
         case (csr_index)
            owhsr_pkg::REG_SENSOR_MODEL: sensor_model_in = csr_pwdata[1:0];
            owhsr_pkg::REG_FRAME_GAP:    frame_gap_in    = csr_pwdata;
            owhsr_pkg::REG_ONE_BIT:      one_bit_in      = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         owhsr_pkg::REG_SENSOR_MODEL: csr_prdata = {30'd0, sensor_model_ff};
         owhsr_pkg::REG_FRAME_GAP:    csr_prdata = frame_gap_ff;
         owhsr_pkg::REG_ONE_BIT:      csr_prdata = one_bit_ff;
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // ---------------- flow control ----------------
   assign out_en     = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = dec_valid_ff && !out_en;
   assign req_accept = req_valid && !req_stall;
   assign is_timeout = (req_op == owhsr_pkg::OP_TIMEOUT);

   // ---------------- bit collection ----------------
   assign gap = req_edge_time - prev_edge_ff;

   always_comb begin
      bits_in      = bits_ff;
      prev_edge_in = prev_edge_ff;
      if (req_accept) begin
         if (is_timeout) begin
            bits_in = '0;
         end else begin
            prev_edge_in = req_edge_time;
            if (gap > {32'd0, frame_gap_ff}) begin
               bits_in = '0;
            end else begin
               // shift in the new bit, keep the latest 40
               bits_in = {bits_ff[owhsr_pkg::FRAME_BITS-2:0],
                          (gap > {32'd0, one_bit_ff})};
            end
         end
      end
   end

   // ---------------- frame stage ----------------
   always_comb begin
      dec_valid_in = dec_valid_ff;
      dec_bits_in  = dec_bits_ff;
      if (req_accept && is_timeout) begin
         dec_valid_in = 1'b1;
         dec_bits_in  = bits_ff;
      end else if (out_en) begin
         dec_valid_in = 1'b0;
      end
   end

   owhsr_decode u_decode (
      .frame_bits   (dec_bits_ff),
      .sensor_model (sensor_model_ff),
      .result       (dec_result)
   );

   // ---------------- result stage ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_en) begin
         rsp_valid_in = dec_valid_ff;
         rsp_word_in  = dec_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_word_ff.status;
   assign rsp_temperature_tenths = rsp_word_ff.temperature;
   assign rsp_humidity_tenths    = rsp_word_ff.humidity;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_model_ff <= owhsr_pkg::SENSOR_MODEL_RESET;
         frame_gap_ff    <= owhsr_pkg::FRAME_GAP_RESET;
         one_bit_ff      <= owhsr_pkg::ONE_BIT_RESET;
         bits_ff         <= '0;
         prev_edge_ff    <= '0;
         dec_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sensor_model_ff <= sensor_model_in;
         frame_gap_ff    <= frame_gap_in;
         one_bit_ff      <= one_bit_in;
         bits_ff         <= bits_in;
         prev_edge_ff    <= prev_edge_in;
         dec_valid_ff    <= dec_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_bits_ff <= dec_bits_in;
      rsp_word_ff <= rsp_word_in;
   end

   // ---------------- assertions ----------------
   a_timeout_clears_bits: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_timeout) |=> (bits_ff == '0))
      else $error("bit register not cleared after timeout");

   a_edge_updates_time: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_timeout) |=> (prev_edge_ff == $past(req_edge_time)))
      else $error("previous edge time not updated");

   a_not_good_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.status != owhsr_pkg::STATUS_GOOD))
         |-> (rsp_word_ff.temperature == 16'sd0 && rsp_word_ff.humidity == 16'd0))
      else $error("values reported on a bad frame");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (dec_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   a_timeout_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_timeout) |=> dec_valid_ff)
      else $error("accepted timeout lost before decode");

endmodule : one_wire_humidity_sensor_receiver

`default_nettype wire
